// ===== rtl/dpt_pkg.sv =====
`timescale 1ns / 1ps
package dpt_pkg;

	localparam int TIME_BITS = 32;
	localparam int QUO_W     = 32;
	localparam int CNT_W     = $clog2(QUO_W);
	localparam int DIST_W    = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_INC  = 2'd2;

	localparam logic [7:0]        DEBOUNCE_RST  = 8'd2;
	localparam logic [QUO_W-1:0]  SPEED_NUM_RST = 32'd20588835;
	localparam logic [31:0]       DIST_INC_RST  = 32'd20589;

	typedef struct packed {
		logic                 hit;
		logic [TIME_BITS-1:0] now;
		logic [TIME_BITS-1:0] interval;
	} qual_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/debounced_pulse_tachometer.sv =====
`timescale 1ns / 1ps
// Debounced encoder pulse tachometer.
// Slave stream: one word per millisecond tick, s_tdata[0] is the sampled pin
// level. Master stream: one word per accepted pulse, carrying pulse count,
// speed (Q16.16), distance (Q32.16, saturating) and the tick number.
// Configuration: cfg_we with cfg_index 0 debounce_ms, 1 speed_numerator,
// 2 distance_per_pulse; index 3 is ignored. Write only while idle.
// Timing: a tick with no accepted pulse leaves the block idle, so such ticks
// can follow back to back. A tick that accepts a pulse starts the restoring
// divider, one quotient bit per cycle; after the last bit the divider's done
// flag moves the block to its wait state, and the word is loaded into the
// output register once that register is free. s_tready stays low meanwhile.
// Stall: the output register holds its word until m_tready; new ticks are
// still taken meanwhile, but a second pulse waits after its division until
// the output register is free.
// Reset: all counters, qualifier state and the output clear; registers take
// their default values.
module debounced_pulse_tachometer
	import dpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [0] pin_level, [7:1] zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [143:0]         m_tdata,   // pulse_total, speed_q16, distance_q16, time_stamp
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_WAIT
	} state_t;

	state_t               state_q;
	logic [7:0]           debounce_q;
	logic [QUO_W-1:0]     speed_num_q;
	logic [31:0]          dist_inc_q;
	logic [31:0]          pulse_cnt_q;
	logic [DIST_W-1:0]    dist_q;
	logic [31:0]          ts_q;
	logic                 out_valid_q;
	logic [143:0]         out_data_q;

	qual_t                qual;
	div_status_t          div_st;
	logic [QUO_W-1:0]     quotient;
	logic                 take;
	logic                 start;
	logic                 out_free;
	logic [DIST_W:0]      dist_sum;
	logic [63:0]          now_ext;

	assign s_tready = (state_q == S_IDLE);
	assign take     = s_tvalid && s_tready;
	assign start    = take && qual.hit;
	assign out_free = !out_valid_q || m_tready;
	assign dist_sum = {1'b0, dist_q} + (DIST_W + 1)'(dist_inc_q);
	assign now_ext  = 64'(qual.now);

	dpt_qualifier u_qual (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.level    (s_tdata[0]),
		.debounce (debounce_q),
		.qual     (qual)
	);

	dpt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (speed_num_q),
		.divisor  (qual.interval),
		.status   (div_st),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			speed_num_q <= SPEED_NUM_RST;
			dist_inc_q  <= DIST_INC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  debounce_q  <= cfg_data[7:0];
				REG_SPEED_NUM: speed_num_q <= cfg_data[QUO_W-1:0];
				REG_DIST_INC:  dist_inc_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pulse_cnt_q <= '0;
			dist_q      <= '0;
			ts_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (state_q == S_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pulse_cnt_q <= pulse_cnt_q + 1'b1;
						dist_q      <= dist_sum[DIST_W] ? {DIST_W{1'b1}} : dist_sum[DIST_W-1:0];
						ts_q        <= now_ext[31:0];
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						out_data_q  <= {ts_q, dist_q, quotient, pulse_cnt_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == S_DIV)
		else $error("divider finished outside division state");
	a_start_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == S_DIV) && div_st.busy)
		else $error("accepted pulse did not start division");
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> $stable(pulse_cnt_q))
		else $error("pulse count changed without an accepted pulse");
	a_div_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> state_q == S_DIV)
		else $error("divider busy while block is not dividing");
`endif

endmodule

// ===== rtl/dpt_qualifier.sv =====
`timescale 1ns / 1ps
module dpt_qualifier
	import dpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       level,
	input  logic [7:0] debounce,
	output qual_t      qual
);

	logic                 armed_q;
	logic                 cap_q;
	logic                 prev_q;
	logic [TIME_BITS-1:0] edge_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [TIME_BITS-1:0] last_q;

	logic                 rise;
	logic                 armed_n;
	logic                 cap_n;
	logic [TIME_BITS-1:0] edge_n;
	logic [TIME_BITS-1:0] elapsed;

	always_comb begin
		rise    = level && !prev_q;
		armed_n = armed_q || rise;
		cap_n   = rise ? level : cap_q;
		edge_n  = rise ? tick_q : edge_q;
		elapsed = tick_q - edge_n;
		qual.now      = tick_q;
		qual.interval = tick_q - last_q;
		qual.hit      = armed_n && (cap_n == level) && (elapsed > TIME_BITS'(debounce));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			cap_q   <= 1'b0;
			prev_q  <= 1'b0;
			edge_q  <= '0;
			tick_q  <= '0;
			last_q  <= '0;
		end else if (take) begin
			armed_q <= qual.hit ? 1'b0 : armed_n;
			cap_q   <= cap_n;
			edge_q  <= edge_n;
			prev_q  <= level;
			tick_q  <= tick_q + 1'b1;
			if (qual.hit) begin
				last_q <= tick_q;
			end
		end
	end

endmodule

// ===== rtl/dpt_divider.sv =====
`timescale 1ns / 1ps
module dpt_divider
	import dpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [QUO_W-1:0]     dividend,
	input  logic [TIME_BITS-1:0] divisor,
	output div_status_t          status,
	output logic [QUO_W-1:0]     quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TIME_BITS-1:0] div_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [QUO_W-1:0]     quo_q;

	logic [TIME_BITS:0]   shifted;
	logic                 fits;

	// zero divisor yields an all-ones quotient, which is the saturated speed
	always_comb begin
		shifted = {rem_q, quo_q[QUO_W-1]};
		fits    = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? TIME_BITS'(shifted - {1'b0, div_q}) : shifted[TIME_BITS-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule
